/* src/epoch_folding_accumulator_macros.svh */
// Assertion macros used by the checker file
`ifndef EPOCH_FOLDING_ACCUMULATOR_MACROS_SVH
`define EPOCH_FOLDING_ACCUMULATOR_MACROS_SVH

// check a property while out of reset
`define EFA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");

// check a property at every edge, reset included
`define EFA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m failed");

`endif

/* src/efa_pkg.sv */
// Package with shared constants and types of the epoch folding accumulator
`default_nettype none
package efa_pkg;
  localparam int MAX_BINS  = 4096;
  localparam int BIN_W     = 12;
  localparam int SUM_W     = 64;
  localparam int CNT_W     = 40;
  localparam int PH_W      = 48;
  localparam int FRAC_W    = 32;
  localparam int NB_W      = 13;
  localparam int SMP_W     = 32;
  localparam int AVG_W     = 32;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 1;
  localparam int STEP_W    = 7;
  localparam int WORD_W    = SUM_W + CNT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 1'd1;
  localparam logic [NB_W-1:0]      NUM_BINS_RST   = 13'd1024;
  localparam logic [PH_W-1:0]      PHASE_STEP_RST = 48'h0001_0000_0000;
  localparam logic [NB_W-1:0]      MIN_BINS       = 13'd2;
  localparam logic [NB_W-1:0]      MAX_BINS_V     = 13'd4096;
  localparam logic                 FUNC_ACC       = 1'b0;
  localparam logic [STEP_W-1:0]    DIV_PH_STEPS   = 7'd17;
  localparam logic [STEP_W-1:0]    DIV_AVG_STEPS  = 7'd64;

  typedef enum logic [1:0] {
    DIV_PH1 = 2'd0,
    DIV_PH2 = 2'd1,
    DIV_AVG = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     div_start;
    div_sel_t div_sel;
    logic     ph_fin;
    logic     ram_we;
    logic     clr_we;
    logic     rd_idx;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic clr_last;
    logic out_busy;
  } status_t;
endpackage
`default_nettype wire

/* src/efa_ram.sv */
// Generic single write port, single read port RAM with registered read
`default_nettype none
module efa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/efa_ctrl.sv */
// Controller state machine of the epoch folding accumulator
`default_nettype none
module efa_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_func,
  output logic                  in_ready,
  input  wire efa_pkg::status_t status,
  output efa_pkg::cmd_t         cmd
);
  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_RED1  = 9'b000000100,
    S_ARD   = 9'b000001000,
    S_AWR   = 9'b000010000,
    S_RED2  = 9'b000100000,
    S_RRD   = 9'b001000000,
    S_RCAP  = 9'b010000000,
    S_ROUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   rdiv_r, rdiv_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      rdiv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdiv_r  <= rdiv_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    rdiv_nxt  = rdiv_r;
    cmd       = '0;
    cmd.div_sel = efa_pkg::DIV_PH1;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (in_func == efa_pkg::FUNC_ACC) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = efa_pkg::DIV_PH1;
            state_nxt     = S_RED1;
          end else begin
            state_nxt = S_RRD;
          end
        end
      end
      S_RED1: begin
        if (!status.div_busy) begin
          cmd.ph_fin = 1'b1;
          state_nxt  = S_ARD;
        end
      end
      S_ARD: begin
        state_nxt = S_AWR;
      end
      S_AWR: begin
        cmd.ram_we    = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel   = efa_pkg::DIV_PH2;
        state_nxt     = S_RED2;
      end
      S_RED2: begin
        if (!status.div_busy) begin
          cmd.ph_fin = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_RRD: begin
        cmd.rd_idx = 1'b1;
        state_nxt  = S_RCAP;
      end
      S_RCAP: begin
        cmd.rd_idx    = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel   = efa_pkg::DIV_AVG;
        rdiv_nxt      = 1'b1;
        state_nxt     = S_ROUT;
      end
      S_ROUT: begin
        if (rdiv_r && !status.div_busy) begin
          rdiv_nxt = 1'b0;
        end
        if (!rdiv_r && !status.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end
endmodule
`default_nettype wire

/* src/efa_dp.sv */
// Datapath: phase, bin store, shared shift-subtract divider and result register
`default_nettype none
module efa_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire efa_pkg::cmd_t                 cmd,
  output efa_pkg::status_t                   status,
  input  wire logic                          cfg_we,
  input  wire logic [efa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [efa_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic signed [efa_pkg::SMP_W-1:0] in_sample,
  input  wire logic [efa_pkg::BIN_W-1:0]     in_bin_index,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [efa_pkg::BIN_W-1:0]          out_read_bin,
  output logic signed [efa_pkg::SUM_W-1:0]   out_bin_sum,
  output logic [efa_pkg::CNT_W-1:0]          out_bin_count,
  output logic signed [efa_pkg::AVG_W-1:0]   out_bin_average,
  output logic                               out_bin_empty
);
  logic [efa_pkg::NB_W-1:0]     num_bins_r;
  logic [efa_pkg::PH_W-1:0]     phase_step_r, phase_r;
  logic [efa_pkg::FRAC_W-1:0]   frac_r;
  logic [efa_pkg::SMP_W-1:0]    sample_r;
  logic [efa_pkg::BIN_W-1:0]    idx_r, bin_r, clr_addr_r;
  logic [efa_pkg::CNT_W:0]      rem_r, trial;
  logic [efa_pkg::SUM_W-1:0]    quo_r, mag, sum_r;
  logic [efa_pkg::CNT_W-1:0]    dvs_r, cnt_r;
  logic [efa_pkg::STEP_W-1:0]   step_r;
  logic [efa_pkg::NB_W-1:0]     eff;
  logic [efa_pkg::PH_W:0]       psum;
  logic [efa_pkg::WORD_W-1:0]   rdata, wdata;
  logic [efa_pkg::SUM_W-1:0]    rsum, new_sum;
  logic [efa_pkg::CNT_W-1:0]    rcnt, new_cnt;
  logic [efa_pkg::SUM_W:0]      tsum;
  logic [efa_pkg::BIN_W-1:0]    waddr, raddr;
  logic [efa_pkg::AVG_W-1:0]    avg;
  logic                         out_valid_r;

  assign rsum = rdata[efa_pkg::WORD_W-1 -: efa_pkg::SUM_W];
  assign rcnt = rdata[efa_pkg::CNT_W-1:0];

  always_comb begin
    eff = num_bins_r;
    if (num_bins_r < efa_pkg::MIN_BINS) begin
      eff = efa_pkg::MIN_BINS;
    end else if (num_bins_r > efa_pkg::MAX_BINS_V) begin
      eff = efa_pkg::MAX_BINS_V;
    end
  end

  assign psum  = {1'b0, phase_r} + {1'b0, phase_step_r};
  assign mag   = rsum[efa_pkg::SUM_W-1] ? (~rsum + 64'd1) : rsum;
  assign trial = {rem_r[efa_pkg::CNT_W-1:0], quo_r[efa_pkg::SUM_W-1]};

  assign tsum = {rsum[efa_pkg::SUM_W-1], rsum}
              + {{(efa_pkg::SUM_W-efa_pkg::SMP_W+1){sample_r[efa_pkg::SMP_W-1]}}, sample_r};
  always_comb begin
    new_sum = tsum[efa_pkg::SUM_W-1:0];
    if (tsum[efa_pkg::SUM_W] != tsum[efa_pkg::SUM_W-1]) begin
      new_sum = tsum[efa_pkg::SUM_W] ? {1'b1, {(efa_pkg::SUM_W-1){1'b0}}}
                                     : {1'b0, {(efa_pkg::SUM_W-1){1'b1}}};
    end
    new_cnt = (&rcnt) ? rcnt : rcnt + 40'd1;
  end

  assign wdata = cmd.clr_we ? '0 : {new_sum, new_cnt};
  assign waddr = cmd.clr_we ? clr_addr_r : bin_r;
  assign raddr = cmd.rd_idx ? idx_r : bin_r;

  efa_ram #(
    .WIDTH(efa_pkg::WORD_W),
    .DEPTH(efa_pkg::MAX_BINS)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.ram_we | cmd.clr_we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bins_r   <= efa_pkg::NUM_BINS_RST;
      phase_step_r <= efa_pkg::PHASE_STEP_RST;
      phase_r      <= '0;
      step_r       <= '0;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == efa_pkg::CFG_NUM_BINS) begin
        num_bins_r <= cfg_wdata[efa_pkg::NB_W-1:0];
      end
      if (cfg_we && cfg_index == efa_pkg::CFG_PHASE_STEP) begin
        phase_step_r <= cfg_wdata[efa_pkg::PH_W-1:0];
      end
      if (cmd.clr_we) begin
        clr_addr_r <= clr_addr_r + 12'd1;
      end
      if (cmd.ph_fin) begin
        phase_r <= {{(efa_pkg::PH_W-efa_pkg::FRAC_W-efa_pkg::BIN_W){1'b0}},
                    rem_r[efa_pkg::BIN_W-1:0], frac_r};
      end
      if (cmd.div_start) begin
        step_r <= (cmd.div_sel == efa_pkg::DIV_AVG) ? efa_pkg::DIV_AVG_STEPS
                                                    : efa_pkg::DIV_PH_STEPS;
      end else if (step_r != '0) begin
        step_r <= step_r - 7'd1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      sample_r <= in_sample;
      idx_r    <= in_bin_index;
    end
    if (cmd.ph_fin) begin
      bin_r <= rem_r[efa_pkg::BIN_W-1:0];
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      case (cmd.div_sel)
        efa_pkg::DIV_PH1: begin
          quo_r  <= {1'b0, phase_r[efa_pkg::PH_W-1:efa_pkg::FRAC_W], 47'd0};
          dvs_r  <= {27'd0, eff};
          frac_r <= phase_r[efa_pkg::FRAC_W-1:0];
        end
        efa_pkg::DIV_PH2: begin
          quo_r  <= {psum[efa_pkg::PH_W:efa_pkg::FRAC_W], 47'd0};
          dvs_r  <= {27'd0, eff};
          frac_r <= psum[efa_pkg::FRAC_W-1:0];
        end
        default: begin
          quo_r <= mag;
          dvs_r <= rcnt;
          sum_r <= rsum;
          cnt_r <= rcnt;
        end
      endcase
    end else if (step_r != '0) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_r <= trial - {1'b0, dvs_r};
        quo_r <= {quo_r[efa_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        quo_r <= {quo_r[efa_pkg::SUM_W-2:0], 1'b0};
      end
    end
    if (cmd.load_out) begin
      out_read_bin    <= idx_r;
      out_bin_sum     <= sum_r;
      out_bin_count   <= cnt_r;
      out_bin_average <= (cnt_r == '0) ? '0 : avg;
      out_bin_empty   <= (cnt_r == '0);
    end
  end

  always_comb begin
    if (!sum_r[efa_pkg::SUM_W-1]) begin
      avg = (quo_r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo_r[efa_pkg::AVG_W-1:0];
    end else begin
      avg = (quo_r > 64'h8000_0000) ? 32'h8000_0000
                                    : ~quo_r[efa_pkg::AVG_W-1:0] + 32'd1;
    end
  end

  assign out_valid       = out_valid_r;
  assign status.div_busy = (step_r != '0);
  assign status.clr_last = (&clr_addr_r);
  assign status.out_busy = out_valid_r & ~out_ready;
endmodule
`default_nettype wire

/* src/epoch_folding_accumulator.sv */
// Top level of the epoch folding accumulator
// Folds power samples into phase bins and reports one bin's sum, count and
// average on request. After reset the bin store is swept to zero, one bin per
// cycle, with in_ready low; configuration writes are taken meanwhile. An
// accumulate item runs two 17-step shift-subtract passes that reduce the phase
// modulo num_bins, around a read-modify-write of the bin store, before the
// next item is taken. A read item reads its bin, runs the 64-step divider that
// forms the average and then loads the result register, after any wait for the
// previous result to be taken. A new item is accepted while a result waits.
`default_nettype none
module epoch_folding_accumulator (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_func,
  input  wire logic signed [efa_pkg::SMP_W-1:0] in_sample,
  input  wire logic [efa_pkg::BIN_W-1:0]        in_bin_index,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [efa_pkg::BIN_W-1:0]             out_read_bin,
  output logic signed [efa_pkg::SUM_W-1:0]      out_bin_sum,
  output logic [efa_pkg::CNT_W-1:0]             out_bin_count,
  output logic signed [efa_pkg::AVG_W-1:0]      out_bin_average,
  output logic                                  out_bin_empty,
  input  wire logic                             cfg_we,
  input  wire logic [efa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [efa_pkg::CFG_W-1:0]        cfg_wdata
);
  efa_pkg::cmd_t    cmd;
  efa_pkg::status_t status;

  efa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_func (in_func),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  efa_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_sample      (in_sample),
    .in_bin_index   (in_bin_index),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_read_bin   (out_read_bin),
    .out_bin_sum    (out_bin_sum),
    .out_bin_count  (out_bin_count),
    .out_bin_average(out_bin_average),
    .out_bin_empty  (out_bin_empty)
  );
endmodule
`default_nettype wire

/* src/efa_checker.sv */
// Port-level checker of the epoch folding accumulator and its bind
`default_nettype none
`include "epoch_folding_accumulator_macros.svh"
module efa_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             in_func,
  input wire logic signed [efa_pkg::SMP_W-1:0] in_sample,
  input wire logic [efa_pkg::BIN_W-1:0]        in_bin_index,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [efa_pkg::BIN_W-1:0]        out_read_bin,
  input wire logic signed [efa_pkg::SUM_W-1:0] out_bin_sum,
  input wire logic [efa_pkg::CNT_W-1:0]        out_bin_count,
  input wire logic signed [efa_pkg::AVG_W-1:0] out_bin_average,
  input wire logic                             out_bin_empty,
  input wire logic                             cfg_we,
  input wire logic [efa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input wire logic [efa_pkg::CFG_W-1:0]        cfg_wdata
);
  `EFA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_bin_sum) && $stable(out_read_bin))
  `EFA_ASSERT(a_empty_zero, out_valid && out_bin_empty |-> out_bin_average == 0 && out_bin_count == 0)
  `EFA_ASSERT(a_count_empty, out_valid && out_bin_count == 0 |-> out_bin_empty)
  `EFA_ASSERT(a_avg_sign, out_valid && !out_bin_empty && !out_bin_sum[63] |-> !out_bin_average[31])
  `EFA_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !in_ready)
endmodule

bind epoch_folding_accumulator efa_checker u_efa_checker (.*);
`default_nettype wire
